// ===== rtl/core/dad_pkg.sv =====
// Shared widths, constants and types for the date adder.
// No dependencies; imported by every module of the block.
package dad_pkg;

  // Field widths of the request and result.
  localparam int unsigned DayW  = 5;
  localparam int unsigned MonW  = 4;
  localparam int unsigned YearW = 14;
  localparam int unsigned CntW  = 15;

  // Running day count: months before the start, day and count never exceed 16 bits.
  localparam int unsigned RemW  = 16;

  // Position of the year in the 400-year Gregorian cycle.
  localparam int unsigned CycW  = 9;

  // Calendar constants.
  localparam logic [RemW-1:0] YearsPerCycle = RemW'(400);
  localparam logic [CycW-1:0] LastCycYear   = CycW'(399);
  localparam logic [CycW-1:0] Century1      = CycW'(100);
  localparam logic [CycW-1:0] Century2      = CycW'(200);
  localparam logic [CycW-1:0] Century3      = CycW'(300);
  localparam logic [MonW-1:0] MonthFirst    = MonW'(1);
  localparam logic [MonW-1:0] MonthLast     = MonW'(12);

  // Operation of the shared adder.
  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_e;

  typedef struct packed {
    alu_op_e         op;
    logic [RemW-1:0] a;
    logic [RemW-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [RemW-1:0] res;
    logic            ge;   // a >= b, valid for a subtraction
    logic            gt;   // a >  b, valid for a subtraction
  } alu_rsp_t;

endpackage

// ===== rtl/core/dad_alu.sv =====
// Shared add/subtract and compare unit of the date adder.
// Depends on dad_pkg for widths and the request and response types.
module dad_alu
  import dad_pkg::*;
(
  input  alu_req_t req_i,
  output alu_rsp_t rsp_o
);

  logic            sub;
  logic [RemW-1:0] b_mod;
  logic [RemW:0]   sum;

  // One carry chain serves both operations; a subtraction adds the inverted operand.
  assign sub   = (req_i.op == ALU_SUB);
  assign b_mod = sub ? ~req_i.b : req_i.b;
  assign sum   = {1'b0, req_i.a} + {1'b0, b_mod} + {{RemW{1'b0}}, sub};

  // The carry out of a subtraction means no borrow, so a is at least b.
  assign rsp_o.res = sum[RemW-1:0];
  assign rsp_o.ge  = sum[RemW];
  assign rsp_o.gt  = sum[RemW] && (sum[RemW-1:0] != '0);

endmodule

// ===== rtl/core/dad_mlen.sv =====
// Month length lookup with the Gregorian leap rule.
// Depends on dad_pkg for widths and calendar constants.
module dad_mlen
  import dad_pkg::*;
(
  input  logic [MonW-1:0] month_i,
  input  logic [CycW-1:0] cyc_i,
  output logic [DayW-1:0] len_o
);

  // Lengths of a common year; index 0 is January.
  localparam logic [DayW-1:0] LenTab [12] = '{
    DayW'(31), DayW'(28), DayW'(31), DayW'(30), DayW'(31), DayW'(30),
    DayW'(31), DayW'(31), DayW'(30), DayW'(31), DayW'(30), DayW'(31)
  };

  logic century;
  logic leap;

  // The year modulo 4 equals its cycle position modulo 4, since 400 is a multiple of 4.
  assign century = (cyc_i == Century1) || (cyc_i == Century2) || (cyc_i == Century3);
  assign leap    = (cyc_i == '0) || ((cyc_i[1:0] == 2'b00) && !century);

  // Months outside January to December have no days.
  always_comb begin
    case (month_i)
      4'd1, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11, 4'd12: begin
        len_o = LenTab[month_i - MonthFirst];
      end
      4'd2: begin
        len_o = leap ? DayW'(29) : DayW'(28);
      end
      default: begin
        len_o = '0;
      end
    endcase
  end

endmodule

// ===== rtl/core/date_add_days.sv =====
// Gregorian date plus a day count: one request gives one result, and a new request is taken
// only after the previous result has been handed over. All arithmetic runs through one 16-bit
// adder, one step per cycle: the year is placed in the 400-year cycle by repeated subtraction
// of 400, the months before the start month are summed, the day and the count are added, and
// the months are then walked one by one until the remainder fits in the current month, after
// which the result is held until it is taken.
// Depends on dad_pkg, dad_alu and dad_mlen.
module date_add_days
  import dad_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [DayW-1:0]  start_day_i,
  input  logic [MonW-1:0]  start_month_i,
  input  logic [YearW-1:0] start_year_i,
  input  logic [CntW-1:0]  days_to_add_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [DayW-1:0]  end_day_o,
  output logic [MonW-1:0]  end_month_o,
  output logic [YearW-1:0] end_year_o
);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_MOD  = 7'b0000010,
    ST_SUM  = 7'b0000100,
    ST_ADDD = 7'b0001000,
    ST_ADDN = 7'b0010000,
    ST_WALK = 7'b0100000,
    ST_DONE = 7'b1000000
  } state_e;

  state_e           state_q, state_d;
  logic [RemW-1:0]  rem_q, rem_d;
  logic [MonW-1:0]  m_q, m_d;
  logic [MonW-1:0]  mon_q, mon_d;
  logic [DayW-1:0]  day_q, day_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [YearW-1:0] year_q, year_d;
  logic [CycW-1:0]  cyc_q, cyc_d;

  alu_req_t         alu_req;
  alu_rsp_t         alu_rsp;
  logic [DayW-1:0]  len;

  dad_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  dad_mlen u_mlen (
    .month_i (m_q),
    .cyc_i   (cyc_q),
    .len_o   (len)
  );

  // Operand selection for the shared adder in each step.
  always_comb begin
    alu_req.op = ALU_ADD;
    alu_req.a  = rem_q;
    alu_req.b  = '0;
    case (state_q)
      ST_MOD: begin
        alu_req.op = ALU_SUB;
        alu_req.b  = YearsPerCycle;
      end
      ST_SUM: begin
        alu_req.b = RemW'(len);
      end
      ST_ADDD: begin
        alu_req.b = RemW'(day_q);
      end
      ST_ADDN: begin
        alu_req.b = RemW'(cnt_q);
      end
      ST_WALK: begin
        alu_req.op = ALU_SUB;
        alu_req.b  = RemW'(len);
      end
      default: begin
        alu_req.b = '0;
      end
    endcase
  end

  // Sequencer: reduce the year, sum earlier months, add day and count, then walk the months.
  always_comb begin
    state_d = state_q;
    rem_d   = rem_q;
    m_d     = m_q;
    mon_d   = mon_q;
    day_d   = day_q;
    cnt_d   = cnt_q;
    year_d  = year_q;
    cyc_d   = cyc_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          day_d   = start_day_i;
          mon_d   = start_month_i;
          cnt_d   = days_to_add_i;
          year_d  = start_year_i;
          rem_d   = RemW'(start_year_i);
          state_d = ST_MOD;
        end
      end
      ST_MOD: begin
        if (alu_rsp.ge) begin
          rem_d = alu_rsp.res;
        end else begin
          cyc_d   = rem_q[CycW-1:0];
          rem_d   = '0;
          m_d     = MonthFirst;
          state_d = ST_SUM;
        end
      end
      ST_SUM: begin
        if (m_q < mon_q) begin
          rem_d = alu_rsp.res;
          m_d   = m_q + MonW'(1);
        end else begin
          state_d = ST_ADDD;
        end
      end
      ST_ADDD: begin
        rem_d   = alu_rsp.res;
        state_d = ST_ADDN;
      end
      ST_ADDN: begin
        rem_d   = alu_rsp.res;
        m_d     = MonthFirst;
        state_d = ST_WALK;
      end
      ST_WALK: begin
        if (alu_rsp.gt) begin
          rem_d = alu_rsp.res;
          if (m_q == MonthLast) begin
            m_d    = MonthFirst;
            year_d = year_q + YearW'(1);
            cyc_d  = (cyc_q == LastCycYear) ? '0 : cyc_q + CycW'(1);
          end else begin
            m_d = m_q + MonW'(1);
          end
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Working registers; each is written before it is read.
  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    m_q    <= m_d;
    mon_q  <= mon_d;
    day_q  <= day_d;
    cnt_q  <= cnt_d;
    year_q <= year_d;
    cyc_q  <= cyc_d;
  end

  // Handshake and result.
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_DONE);
  assign end_day_o   = rem_q[DayW-1:0];
  assign end_month_o = m_q;
  assign end_year_o  = year_q;

  // An accepted request always starts with the year reduction.
  a_start_mod : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_MOD))
    else $error("request accepted without entering the year reduction");

  // While walking, the month counter stays within a real month.
  a_walk_month : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> ((m_q >= MonthFirst) && (m_q <= MonthLast)))
    else $error("month counter left January to December during the walk");

  // The cycle position stays below 400 and agrees with the year modulo 4.
  a_cycle_pos : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_SUM) || (state_q == ST_WALK)) |->
      ((cyc_q <= LastCycYear) && (cyc_q[1:0] == year_q[1:0])))
    else $error("400-year cycle position out of step with the year");

  // A finished result always fits in a month.
  a_day_fits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (rem_q <= RemW'(31)))
    else $error("result day does not fit in a month");

endmodule
